/* sv/barometric_pressure_compensation_core_assert.svh */
// Assertion macros shared by the checker of the compensation core.
// Depends on nothing; every macro takes its clock and active-low reset.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
// Same-cycle implication.
`define BMPC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("bmpc assertion failed");
// Next-cycle implication.
`define BMPC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("bmpc assertion failed");
`endif

/* sv/bmpc_pkg.sv */
// Types, register indexes, constants and helper functions of the compensation core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bmpc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure_word;
    } in_word_t;

    typedef struct packed {
        logic signed [27:0] temperature_deci_c;
        logic signed [31:0] pressure_pa;
        logic               divide_error;
    } out_word_t;

    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0]  oss;
    } cal_t;

    typedef struct packed {
        logic     valid;
        in_word_t word;
    } queue_head_t;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MC_MD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OSS     = 3'd5;

    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int DIV_SIDE_W_DEFAULT  = 1;

    localparam logic [31:0] T_OFFSET  = 32'd4000;
    localparam logic [31:0] P_ROUND   = 32'd32768;
    localparam logic [31:0] P_SCALE   = 32'd50000;
    localparam logic [31:0] P_MSB     = 32'h8000_0000;
    localparam logic [31:0] C_SQ      = 32'd3038;
    localparam logic [31:0] C_LIN_NEG = 32'hFFFF_E343;
    localparam logic [31:0] C_BIAS    = 32'd3791;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

/* sv/barometric_pressure_compensation_core.sv */
// Top level of the compensation core: calibration registers, front queue, back datapath.
// Depends on bmpc_pkg, bmpc_front and bmpc_back.
//
// Usage:
// - Input channel (in_valid, in_stall, in_data) carries one word holding a raw
//   temperature and a raw 24-bit pressure reading; a word moves when valid is high
//   and stall is low.
// - Output channel (out_valid, out_stall, out_data) returns one word per input word,
//   in order: temperature in tenths of a degree, pressure in pascals, divide error.
// - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
//   calibration and oversampling registers; cfg_ready is always high and indexes
//   past the last register are dropped. Write only while the core is empty.
// - Throughput is one word per cycle while no result is held on out_stall. From
//   acceptance to out_valid a word goes through the queue, then a pipeline of two
//   32-stage dividers (one quotient bit per stage) and the multiply stages around them.
// - Reset clears the registers, the queue and all valid flags; no word is lost
//   or produced by reset beyond those in flight being dropped.
// - When out_stall holds a result, the whole back pipeline halts; the QUEUE_DEPTH-word
//   queue (four by default) keeps taking input until it fills, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation_core #(
    parameter int QUEUE_DEPTH = bmpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire bmpc_pkg::in_word_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output bmpc_pkg::out_word_t                   out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import bmpc_pkg::*;

    cal_t        cal_reg, cal_next;
    queue_head_t head;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AC1_AC2: cal_next.ac1_ac2 = cfg_data;
                REG_AC3_AC4: cal_next.ac3_ac4 = cfg_data;
                REG_AC5_AC6: cal_next.ac5_ac6 = cfg_data;
                REG_B1_B2:   cal_next.b1_b2   = cfg_data;
                REG_MC_MD:   cal_next.mc_md   = cfg_data;
                REG_OSS:     cal_next.oss     = cfg_data[1:0];
                default:     cal_next         = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    bmpc_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .pop      (pop),
        .head     (head)
    );

    bmpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

/* sv/bmpc_front.sv */
// Front end: takes input words off the input channel into a short queue.
// Depends on bmpc_pkg; the back end pops the queue head.
`timescale 1ns / 1ps
`default_nettype none
module bmpc_front #(
    parameter int QUEUE_DEPTH = bmpc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire bmpc_pkg::in_word_t     in_data,
    input  wire logic                   pop,
    output bmpc_pkg::queue_head_t       head
);
    import bmpc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    in_word_t         slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.word  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ((wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

/* sv/bmpc_div.sv */
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on bmpc_pkg; carries a side word alongside each division.
`timescale 1ns / 1ps
`default_nettype none
module bmpc_div #(
    parameter int SIDE_W = bmpc_pkg::DIV_SIDE_W_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       numer,
    input  wire logic [31:0]       denom,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [31:0]            quot,
    output logic [SIDE_W-1:0]      out_side
);
    import bmpc_pkg::*;

    localparam int STEPS = 32;

    logic              valid_reg [0:STEPS];
    logic [31:0]       rem_reg   [0:STEPS];
    logic [31:0]       nq_reg    [0:STEPS];
    logic [31:0]       d_reg     [0:STEPS];
    logic [SIDE_W-1:0] side_reg  [0:STEPS];
    logic [31:0]       rem_next  [0:STEPS-1];
    logic [31:0]       nq_next   [0:STEPS-1];

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            logic [32:0] trial;
            logic [32:0] diff;
            trial = {rem_reg[k], nq_reg[k][31]};
            diff  = trial - {1'b0, d_reg[k]};
            if (!diff[32])
            begin
                rem_next[k] = diff[31:0];
                nq_next[k]  = {nq_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[31:0];
                nq_next[k]  = {nq_reg[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < STEPS; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            nq_reg[0]   <= numer;
            d_reg[0]    <= denom;
            side_reg[0] <= in_side;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                nq_reg[k+1]   <= nq_next[k];
                d_reg[k+1]    <= d_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign quot      = nq_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule
`default_nettype wire

/* sv/bmpc_back.sv */
// Back end: the compensation datapath, two pipelined dividers and the output register.
// Depends on bmpc_pkg and bmpc_div; pops words from the front end queue.
`timescale 1ns / 1ps
`default_nettype none
module bmpc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bmpc_pkg::cal_t        cal,
    input  wire bmpc_pkg::queue_head_t head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output bmpc_pkg::out_word_t        out_data
);
    import bmpc_pkg::*;

    localparam int D1_W = 66;
    localparam int D2_W = 30;

    logic en;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = sx16(cal.ac1_ac2[31:16]);
    assign ac2 = sx16(cal.ac1_ac2[15:0]);
    assign ac3 = sx16(cal.ac3_ac4[31:16]);
    assign ac4 = {16'b0, cal.ac3_ac4[15:0]};
    assign ac5 = {16'b0, cal.ac5_ac6[31:16]};
    assign ac6 = {16'b0, cal.ac5_ac6[15:0]};
    assign b1  = sx16(cal.b1_b2[31:16]);
    assign b2  = sx16(cal.b1_b2[15:0]);
    assign mc  = sx16(cal.mc_md[31:16]);
    assign md  = sx16(cal.mc_md[15:0]);

    // The whole pipeline moves together; it halts only on a held result.
    logic out_valid_reg;
    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && head.valid;

    // Stage 1: temperature product.
    logic        s1_valid_reg;
    logic [31:0] s1_x1m_reg, s1_up_reg;
    logic [31:0] ut, up;
    assign ut = {16'b0, head.word.raw_temperature};
    assign up = {8'b0, head.word.raw_pressure_word} >> (5'd8 - {3'b0, cal.oss});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x1m_reg <= 32'((ut - ac6) * ac5);
            s1_up_reg  <= up;
        end
    end

    // Temperature division, signs handled around an unsigned core.
    logic [31:0] t_x1, t_div, t_num, t_an, t_ad;
    assign t_x1  = sra32(s1_x1m_reg, 5'd15);
    assign t_div = t_x1 + md;
    assign t_num = mc << 11;
    assign t_an  = t_num[31] ? (32'd0 - t_num) : t_num;
    assign t_ad  = t_div[31] ? (32'd0 - t_div) : t_div;

    logic            d1_valid;
    logic [31:0]     d1_q;
    logic [D1_W-1:0] d1_side;

    bmpc_div #(.SIDE_W(D1_W)) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .numer     (t_an),
        .denom     (t_ad),
        .in_side   ({(t_div == 32'd0), (t_num[31] ^ t_div[31]), t_x1, s1_up_reg}),
        .out_valid (d1_valid),
        .quot      (d1_q),
        .out_side  (d1_side)
    );

    // Stage A: temperature result and B6.
    logic        a_valid_reg, a_err_reg;
    logic [27:0] a_temp_reg;
    logic [31:0] a_b6_reg, a_up_reg;
    logic [31:0] a_x2, a_b5, a_temp;
    assign a_x2   = d1_side[64] ? (32'd0 - d1_q) : d1_q;
    assign a_b5   = d1_side[63:32] + a_x2;
    assign a_temp = sra32(a_b5 + 32'd8, 5'd4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_err_reg  <= d1_side[65];
            a_temp_reg <= a_temp[27:0];
            a_b6_reg   <= a_b5 - T_OFFSET;
            a_up_reg   <= d1_side[31:0];
        end
    end

    // Stage B: products of B6.
    logic        b_valid_reg, b_err_reg;
    logic [27:0] b_temp_reg;
    logic [31:0] b_sqm_reg, b_ac2b6_reg, b_ac3b6_reg, b_up_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_err_reg   <= a_err_reg;
            b_temp_reg  <= a_temp_reg;
            b_up_reg    <= a_up_reg;
            b_sqm_reg   <= 32'(a_b6_reg * a_b6_reg);
            b_ac2b6_reg <= 32'(ac2 * a_b6_reg);
            b_ac3b6_reg <= 32'(ac3 * a_b6_reg);
        end
    end

    // Stage C: scaled terms.
    logic        c_valid_reg, c_err_reg;
    logic [27:0] c_temp_reg;
    logic [31:0] c_sq_reg, c_x2a_reg, c_x1c_reg, c_up_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_err_reg  <= b_err_reg;
            c_temp_reg <= b_temp_reg;
            c_up_reg   <= b_up_reg;
            c_sq_reg   <= sra32(b_sqm_reg, 5'd12);
            c_x2a_reg  <= sra32(b_ac2b6_reg, 5'd11);
            c_x1c_reg  <= sra32(b_ac3b6_reg, 5'd13);
        end
    end

    // Stage D: products of the square term.
    logic        d_valid_reg, d_err_reg;
    logic [27:0] d_temp_reg;
    logic [31:0] d_b2sq_reg, d_b1sq_reg, d_x2a_reg, d_x1c_reg, d_up_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_err_reg  <= c_err_reg;
            d_temp_reg <= c_temp_reg;
            d_up_reg   <= c_up_reg;
            d_x2a_reg  <= c_x2a_reg;
            d_x1c_reg  <= c_x1c_reg;
            d_b2sq_reg <= 32'(b2 * c_sq_reg);
            d_b1sq_reg <= 32'(b1 * c_sq_reg);
        end
    end

    // Stage E: B3 and the factor of B4.
    logic        e_valid_reg, e_err_reg;
    logic [27:0] e_temp_reg;
    logic [31:0] e_upb3_reg, e_t_reg;
    logic [31:0] e_x3, e_b3, e_x3b;
    assign e_x3  = sra32(d_b2sq_reg, 5'd11) + d_x2a_reg;
    assign e_b3  = sra32((((ac1 << 2) + e_x3) << cal.oss) + 32'd2, 5'd2);
    assign e_x3b = sra32(d_x1c_reg + sra32(d_b1sq_reg, 5'd16) + 32'd2, 5'd2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_err_reg  <= d_err_reg;
            e_temp_reg <= d_temp_reg;
            e_upb3_reg <= d_up_reg - e_b3;
            e_t_reg    <= e_x3b + P_ROUND;
        end
    end

    // Stage F: B4.
    logic        f_valid_reg, f_err_reg;
    logic [27:0] f_temp_reg;
    logic [31:0] f_b4_reg, f_upb3_reg, f_prod;
    assign f_prod = 32'(ac4 * e_t_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_err_reg  <= e_err_reg;
            f_temp_reg <= e_temp_reg;
            f_upb3_reg <= e_upb3_reg;
            f_b4_reg   <= f_prod >> 15;
        end
    end

    // Stage G: B7.
    logic        g_valid_reg, g_err_reg;
    logic [27:0] g_temp_reg;
    logic [31:0] g_b4_reg, g_b7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_err_reg  <= f_err_reg || (f_b4_reg == 32'd0);
            g_temp_reg <= f_temp_reg;
            g_b4_reg   <= f_b4_reg;
            g_b7_reg   <= 32'(f_upb3_reg * (P_SCALE >> cal.oss));
        end
    end

    // Pressure division; a large B7 is divided first and doubled after.
    logic            b7_big;
    logic            d2_valid;
    logic [31:0]     d2_q;
    logic [D2_W-1:0] d2_side;
    assign b7_big = (g_b7_reg & P_MSB) != 32'd0;

    bmpc_div #(.SIDE_W(D2_W)) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid_reg),
        .numer     (b7_big ? g_b7_reg : (g_b7_reg << 1)),
        .denom     (g_b4_reg),
        .in_side   ({g_err_reg, b7_big, g_temp_reg}),
        .out_valid (d2_valid),
        .quot      (d2_q),
        .out_side  (d2_side)
    );

    // Stage H: correction products.
    logic        h_valid_reg, h_err_reg;
    logic [27:0] h_temp_reg;
    logic [31:0] h_p_reg, h_x1m_reg, h_x2m_reg;
    logic [31:0] h_p, h_ps;
    assign h_p  = d2_side[28] ? (d2_q << 1) : d2_q;
    assign h_ps = sra32(h_p, 5'd8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_err_reg  <= d2_side[29];
            h_temp_reg <= d2_side[27:0];
            h_p_reg    <= h_p;
            h_x1m_reg  <= 32'(h_ps * h_ps);
            h_x2m_reg  <= 32'(C_LIN_NEG * h_p);
        end
    end

    // Stage I: square term times its coefficient.
    logic        i_valid_reg, i_err_reg;
    logic [27:0] i_temp_reg;
    logic [31:0] i_p_reg, i_x1_reg, i_x2m_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_err_reg  <= h_err_reg;
            i_temp_reg <= h_temp_reg;
            i_p_reg    <= h_p_reg;
            i_x2m_reg  <= h_x2m_reg;
            i_x1_reg   <= 32'(h_x1m_reg * C_SQ);
        end
    end

    // Output register.
    out_word_t   out_data_reg;
    logic [31:0] o_sum, o_p;
    assign o_sum = sra32(i_x1_reg, 5'd16) + sra32(i_x2m_reg, 5'd16) + C_BIAS;
    assign o_p   = i_p_reg + sra32(o_sum, 5'd4);

    always_ff @(posedge clk)
    begin
        if (en && i_valid_reg)
        begin
            out_data_reg.divide_error       <= i_err_reg;
            out_data_reg.temperature_deci_c <= i_err_reg ? '0 : $signed(i_temp_reg);
            out_data_reg.pressure_pa        <= i_err_reg ? '0 : $signed(o_p);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= head.valid;
            a_valid_reg   <= d1_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            g_valid_reg   <= f_valid_reg;
            h_valid_reg   <= d2_valid;
            i_valid_reg   <= h_valid_reg;
            out_valid_reg <= i_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* sv/bmpc_checker.sv */
// Port-level checker of the compensation core and the bind that attaches it.
// Depends on bmpc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_pressure_compensation_core_assert.svh"
module bmpc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire bmpc_pkg::out_word_t out_data,
    input wire logic                cfg_ready
);
    import bmpc_pkg::*;

    // A flagged word carries zero readings.
    `BMPC_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && out_data.divide_error, out_data.temperature_deci_c == 28'sd0 && out_data.pressure_pa == 32'sd0)
    // A held word stays offered and unchanged.
    `BMPC_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
    `BMPC_ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall, $stable(out_data))
    // The register file never refuses a write.
    `BMPC_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind barometric_pressure_compensation_core bmpc_checker u_bmpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
